>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> hw/rtl/htd_pkg.sv
// shared types and constants of the code tree decoder
package htd_pkg;

    // request commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_SYMBOL   = 2'd0;
    localparam logic [1:0] KIND_INSERTED = 2'd1;
    localparam logic [1:0] KIND_FULL     = 2'd2;

    // normalized code length, wide enough for length limits up to 127
    localparam int LEN_W = 7;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             command;
        logic [31:0]      code_bits;
        logic [LEN_W-1:0] code_len;
        logic [7:0]       symbol;
        logic             data_bit;
        logic             last_bit;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sym;
        logic       msg_end;
    } res_t;

    typedef struct packed {
        logic has_room;
        logic has_item;
    } q_status_t;

endpackage

>>> hw/rtl/huffman_trie_decoder.sv
// top level of the prefix-code decoder built on a binary code tree
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  request  | in_valid / in_stall  | command code_bits code_length symbol data_bit last_bit
//  result   | out_valid / out_stall| result_kind symbol_out message_end
//
// a request passes the front register and then the queue before it reaches the walker
// a decode takes its child from the cached word of the current node and, unless the
// child is missing, does one node store read that gives its leaf flag
// an insert pops the request, reads the store and then updates it per code bit, then
// writes the leaf and emits the result; reset clears control state only, since nodes are
// handed out in order and each word is written when its node is added
// a stalled result blocks the walker only when its next result is ready

module huffman_trie_decoder
#(
    parameter int NODE_COUNT   = 1024,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] code_bits,
    input  logic [5:0]  code_length,
    input  logic [7:0]  symbol,
    input  logic        data_bit,
    input  logic        last_bit,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  symbol_out,
    output logic        message_end
);

    // request handed from the front to the queue
    htd_pkg::item_t     push_item;
    logic               push;
    // request handed from the queue to the walker
    htd_pkg::item_t     pop_item;
    logic               pop;
    htd_pkg::q_status_t q_status;
    // registered result
    htd_pkg::res_t      result;

    // front: accepts requests and clamps the code length
    htd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .code_bits   (code_bits),
        .code_length (code_length),
        .symbol      (symbol),
        .data_bit    (data_bit),
        .last_bit    (last_bit),
        .q_status    (q_status),
        .q_push      (push),
        .q_item      (push_item)
    );

    // two-entry queue decouples the front from the walker
    htd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    // back: walks the tree, adds nodes, emits symbols and insert status
    htd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_item    (pop_item),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // result fields straight from the output register
    assign result_kind = result.kind;
    assign symbol_out  = result.sym;
    assign message_end = result.msg_end;

endmodule

>>> hw/rtl/htd_queue.sv
// short request queue between the front and the back
module htd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  htd_pkg::item_t      push_item,
    input  logic                pop,
    output htd_pkg::item_t      pop_item,
    output htd_pkg::q_status_t  status
);

    localparam int PW = htd_pkg::QUEUE_PTR_W;
    localparam int CW = htd_pkg::QUEUE_CNT_W;
    localparam logic [PW-1:0] LAST_PTR = PW'(htd_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(htd_pkg::QUEUE_DEPTH);

    htd_pkg::item_t slot_reg [htd_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign status.has_room = (count_reg != FULL_CNT);
    assign status.has_item = (count_reg != '0);
    assign do_push = push && status.has_room;
    assign do_pop  = pop && status.has_item;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/htd_front.sv
// front stage: takes requests and normalizes the code length
module htd_front
#(
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [31:0]         code_bits,
    input  logic [5:0]          code_length,
    input  logic [7:0]          symbol,
    input  logic                data_bit,
    input  logic                last_bit,
    input  htd_pkg::q_status_t  q_status,
    output logic                q_push,
    output htd_pkg::item_t      q_item
);

    localparam int LW = htd_pkg::LEN_W;
    localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_CODE_LEN);

    logic            valid_reg, valid_next;
    htd_pkg::item_t  item_reg;
    htd_pkg::item_t  item_next;
    logic [LW-1:0]   len_raw;
    logic            accept;

    assign in_stall = valid_reg && !q_status.has_room;
    assign accept   = in_valid && !in_stall;
    assign q_push   = valid_reg && q_status.has_room;
    assign q_item   = item_reg;
    assign len_raw  = LW'(code_length);

    always_comb
    begin
        item_next.command   = command;
        item_next.code_bits = code_bits;
        item_next.symbol    = symbol;
        item_next.data_bit  = data_bit;
        item_next.last_bit  = last_bit;
        // zero length counts as one, long codes are cut to the limit
        priority if (len_raw == '0)
        begin
            item_next.code_len = LW'(1);
        end
        else if (len_raw > LEN_LIMIT)
        begin
            item_next.code_len = LEN_LIMIT;
        end
        else
        begin
            item_next.code_len = len_raw;
        end

        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hw/rtl/htd_back.sv
// back stage: tree walker with node store and result register
module htd_back
#(
    parameter int NODE_COUNT = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  htd_pkg::q_status_t  q_status,
    input  htd_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output htd_pkg::res_t       result
);

    localparam int A  = $clog2(NODE_COUNT);
    localparam int CH = 2 * A;
    localparam int W  = CH + 9;
    localparam int LW = htd_pkg::LEN_W;
    localparam logic [A-1:0] LAST_NODE = A'(NODE_COUNT - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DEC_WAIT = 3'd1;
    localparam logic [2:0] S_INS_LOOK = 3'd2;
    localparam logic [2:0] S_INS_EVAL = 3'd3;
    localparam logic [2:0] S_INS_LEAF = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // word: leaf flag, symbol, child for bit one, child for bit zero
    logic [W-1:0] mem [NODE_COUNT];
    logic [W-1:0] rd_data_reg;

    logic          mem_we;
    logic [A-1:0]  mem_waddr;
    logic [W-1:0]  mem_wdata;
    logic          mem_re;
    logic [A-1:0]  mem_raddr;

    logic [2:0]    state_reg, state_next;
    logic [A-1:0]  node_reg, node_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic          fresh_reg, fresh_next;
    logic [31:0]   code_reg, code_next;
    logic [7:0]    sym_reg, sym_next;
    logic [A-1:0]  child_reg, child_next;
    logic          last_reg, last_next;
    logic [1:0]    kind_reg, kind_next;
    logic [A-1:0]  cur_node_reg, cur_node_next;
    logic [CH-1:0] cur_word_reg, cur_word_next;
    logic [CH-1:0] root_word_reg, root_word_next;
    logic [A-1:0]  nodes_used_reg, nodes_used_next;

    logic            out_valid_reg, out_valid_next;
    htd_pkg::res_t   res_reg;
    htd_pkg::res_t   res_next;
    logic            emit;
    logic            slot_free;

    logic [CH-1:0] cur_children;
    logic [A-1:0]  dec_child;
    logic [LW-1:0] pos;
    logic          ins_bit;
    logic [CH-1:0] eval_children;
    logic [A-1:0]  eval_child;
    logic [CH-1:0] upd_children;
    logic [A-1:0]  new_node;
    logic          store_full;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    assign cur_children = (cur_node_reg == '0) ? root_word_reg : cur_word_reg;
    assign dec_child    = q_item.data_bit ? cur_children[CH-1:A] : cur_children[A-1:0];

    // code bits above position 31 read as zero
    assign pos     = rem_reg - LW'(1);
    assign ins_bit = (pos < LW'(32)) ? code_reg[pos[4:0]] : 1'b0;

    assign eval_children = (node_reg == '0) ? root_word_reg :
                           (fresh_reg ? '0 : rd_data_reg[CH-1:0]);
    assign eval_child    = ins_bit ? eval_children[CH-1:A] : eval_children[A-1:0];
    assign new_node      = nodes_used_reg + A'(1);
    assign store_full    = (nodes_used_reg == LAST_NODE);

    always_comb
    begin
        upd_children = eval_children;
        if (ins_bit)
        begin
            upd_children[CH-1:A] = new_node;
        end
        else
        begin
            upd_children[A-1:0] = new_node;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        rem_next        = rem_reg;
        fresh_next      = fresh_reg;
        code_next       = code_reg;
        sym_next        = sym_reg;
        child_next      = child_reg;
        last_next       = last_reg;
        kind_next       = kind_reg;
        cur_node_next   = cur_node_reg;
        cur_word_next   = cur_word_reg;
        root_word_next  = root_word_reg;
        nodes_used_next = nodes_used_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = node_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = node_reg;
        emit            = 1'b0;
        res_next        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_status.has_item)
                begin
                    q_pop = 1'b1;
                    if (q_item.command == htd_pkg::CMD_DECODE)
                    begin
                        last_next = q_item.last_bit;
                        if (dec_child == '0)
                        begin
                            // missing child
                            cur_node_next = '0;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = dec_child;
                            child_next = dec_child;
                            state_next = S_DEC_WAIT;
                        end
                    end
                    else
                    begin
                        node_next  = '0;
                        rem_next   = q_item.code_len;
                        fresh_next = 1'b0;
                        code_next  = q_item.code_bits;
                        sym_next   = q_item.symbol;
                        state_next = S_INS_LOOK;
                    end
                end
            end

            S_DEC_WAIT:
            begin
                if (rd_data_reg[W-1])
                begin
                    if (slot_free)
                    begin
                        emit             = 1'b1;
                        res_next.kind    = htd_pkg::KIND_SYMBOL;
                        res_next.sym     = rd_data_reg[W-2:CH];
                        res_next.msg_end = last_reg;
                        cur_node_next    = '0;
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    cur_node_next = last_reg ? '0 : child_reg;
                    cur_word_next = rd_data_reg[CH-1:0];
                    state_next    = S_IDLE;
                end
            end

            S_INS_LOOK:
            begin
                if (rem_reg == '0)
                begin
                    kind_next = htd_pkg::KIND_INSERTED;
                    if (fresh_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {1'b1, sym_reg, {CH{1'b0}}};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_INS_LEAF;
                    end
                end
                else
                begin
                    mem_re     = (node_reg != '0) && !fresh_reg;
                    state_next = S_INS_EVAL;
                end
            end

            S_INS_LEAF:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b1, sym_reg, rd_data_reg[CH-1:0]};
                state_next = S_DONE;
            end

            S_INS_EVAL:
            begin
                if (eval_child != '0)
                begin
                    node_next  = eval_child;
                    rem_next   = rem_reg - LW'(1);
                    state_next = S_INS_LOOK;
                end
                else if (store_full)
                begin
                    // a node added on this path keeps a clean word
                    mem_we     = fresh_reg;
                    mem_wdata  = '0;
                    kind_next  = htd_pkg::KIND_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    if (node_reg == '0)
                    begin
                        root_word_next = upd_children;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {(fresh_reg ? 9'd0 : rd_data_reg[W-1:CH]), upd_children};
                    end
                    nodes_used_next = new_node;
                    node_next       = new_node;
                    fresh_next      = 1'b1;
                    rem_next        = rem_reg - LW'(1);
                    state_next      = S_INS_LOOK;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    res_next.kind = kind_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // keep the cached word of the decoder position in step with the store
        if (mem_we && (mem_waddr == cur_node_reg) && (cur_node_reg != '0))
        begin
            cur_word_next = mem_wdata[CH-1:0];
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_node_reg   <= '0;
            root_word_reg  <= '0;
            nodes_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            root_word_reg  <= root_word_next;
            nodes_used_reg <= nodes_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        rem_reg      <= rem_next;
        fresh_reg    <= fresh_next;
        code_reg     <= code_next;
        sym_reg      <= sym_next;
        child_reg    <= child_next;
        last_reg     <= last_next;
        kind_reg     <= kind_next;
        cur_word_reg <= cur_word_next;
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

>>> hw/rtl/htd_checker.sv
// port level checks of the decoder and their binding to the top level
`include "assert_macros.svh"

module htd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [7:0]  symbol_out,
    input logic        message_end
);

    logic [10:0] out_word;
    logic        status_out;

    assign out_word   = {result_kind, symbol_out, message_end};
    assign status_out = out_valid && (result_kind != htd_pkg::KIND_SYMBOL);

    // a stalled result stays offered and unchanged
    `ASSERT_HOLDS(a_out_valid_held, out_valid && out_stall |=> out_valid)
    `ASSERT_HOLDS(a_out_payload_held, out_valid && out_stall |=> $stable(out_word))

    // insert status carries no symbol and no message end
    `ASSERT_NEVER(a_status_symbol, status_out && symbol_out != 8'd0)
    `ASSERT_NEVER(a_status_end, status_out && message_end)

endmodule

bind huffman_trie_decoder htd_checker u_checker (.*);
